[rtl/valve_sequencer_with_status_blink_assert.svh]
// Assertion macros for the valve sequencer with status blink.
// Used by the top level; no other dependencies.
`ifndef VALVE_SEQUENCER_WITH_STATUS_BLINK_ASSERT_SVH
`define VALVE_SEQUENCER_WITH_STATUS_BLINK_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define VSB_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
// next-cycle implication
`define VSB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define VSB_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define VSB_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[rtl/vsb_pkg.sv]
// Package for the valve sequencer: mode codes, register indexes, reset values
// and shared types. No dependencies.
`timescale 1ns / 1ps

package vsb_pkg;

    localparam int CFG_BITS       = 11;
    localparam int CFG_IDX_BITS   = 3;
    localparam int TIMER_BITS_DEF = 11;

    typedef enum logic [2:0] {
        MODE_IDLE       = 3'd0,
        MODE_CHARGE     = 3'd1,
        MODE_OPEN       = 3'd2,
        MODE_AFTER_OPEN = 3'd3,
        MODE_RUNNING    = 3'd4,
        MODE_CLOSE      = 3'd5
    } t_mode;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_LOCKOUT      = 3'd0,
        CFG_TRANSITION   = 3'd1,
        CFG_SLOW_PERIOD  = 3'd2,
        CFG_IDLE_HIGH    = 3'd3,
        CFG_CHARGE_HIGH  = 3'd4,
        CFG_RUNNING_HIGH = 3'd5,
        CFG_FAST_PERIOD  = 3'd6,
        CFG_FAST_HIGH    = 3'd7
    } t_cfg_idx;

    localparam logic [CFG_BITS-1:0] RST_LOCKOUT      = 11'd1000;
    localparam logic [CFG_BITS-1:0] RST_TRANSITION   = 11'd50;
    localparam logic [CFG_BITS-1:0] RST_SLOW_PERIOD  = 11'd1000;
    localparam logic [CFG_BITS-1:0] RST_IDLE_HIGH    = 11'd800;
    localparam logic [CFG_BITS-1:0] RST_CHARGE_HIGH  = 11'd500;
    localparam logic [CFG_BITS-1:0] RST_RUNNING_HIGH = 11'd200;
    localparam logic [CFG_BITS-1:0] RST_FAST_PERIOD  = 11'd25;
    localparam logic [CFG_BITS-1:0] RST_FAST_HIGH    = 11'd12;

    typedef struct packed {
        logic [CFG_BITS-1:0] lockout;
        logic [CFG_BITS-1:0] transition;
        logic [CFG_BITS-1:0] slow_period;
        logic [CFG_BITS-1:0] idle_high;
        logic [CFG_BITS-1:0] charge_high;
        logic [CFG_BITS-1:0] running_high;
        logic [CFG_BITS-1:0] fast_period;
        logic [CFG_BITS-1:0] fast_high;
    } t_cfg;

    typedef struct packed {
        logic boost;
        logic buck;
        logic open;
    } t_drive;

endpackage

[rtl/vsb_step.sv]
// Next-state logic for one tick of the valve sequencer.
// Depends on vsb_pkg.
`timescale 1ns / 1ps

module vsb_step #(
    parameter int TIMER_BITS = vsb_pkg::TIMER_BITS_DEF
) (
    input  vsb_pkg::t_mode         i_mode,
    input  logic [TIMER_BITS-1:0]  i_since_change,
    input  logic [TIMER_BITS-1:0]  i_since_blink,
    input  logic                   i_led,
    input  logic                   i_press,
    input  vsb_pkg::t_cfg          i_cfg,
    output vsb_pkg::t_mode         o_mode,
    output logic [TIMER_BITS-1:0]  o_since_change,
    output logic [TIMER_BITS-1:0]  o_since_blink,
    output logic                   o_led,
    output vsb_pkg::t_drive        o_drive
);

    function automatic logic [TIMER_BITS-1:0] sat_inc(input logic [TIMER_BITS-1:0] v);
        sat_inc = (v == {TIMER_BITS{1'b1}}) ? v : v + 1'b1;
    endfunction

    function automatic logic gt_cfg(input logic [TIMER_BITS-1:0] v,
                                    input logic [vsb_pkg::CFG_BITS-1:0] c);
        gt_cfg = v > TIMER_BITS'(c);
    endfunction

    always_comb begin
        logic [TIMER_BITS-1:0] sc;
        logic [TIMER_BITS-1:0] sb;
        logic                  led;
        vsb_pkg::t_mode        mode;
        logic [vsb_pkg::CFG_BITS-1:0] high_after;

        sc   = sat_inc(i_since_change);
        sb   = sat_inc(i_since_blink);
        led  = i_led;
        mode = i_mode;
        high_after = i_cfg.idle_high;

        // press past the lockout: advance, restart both timers, LED low
        if (i_press && gt_cfg(sc, i_cfg.lockout)) begin
            case (mode)
                vsb_pkg::MODE_IDLE:       mode = vsb_pkg::MODE_CHARGE;
                vsb_pkg::MODE_CHARGE:     mode = vsb_pkg::MODE_OPEN;
                vsb_pkg::MODE_OPEN:       mode = vsb_pkg::MODE_AFTER_OPEN;
                vsb_pkg::MODE_AFTER_OPEN: mode = vsb_pkg::MODE_RUNNING;
                vsb_pkg::MODE_RUNNING:    mode = vsb_pkg::MODE_CLOSE;
                default:                  mode = vsb_pkg::MODE_IDLE;
            endcase
            sc  = '0;
            sb  = '0;
            led = 1'b0;
        end

        case (mode)
            vsb_pkg::MODE_IDLE, vsb_pkg::MODE_CHARGE, vsb_pkg::MODE_RUNNING: begin
                if (mode == vsb_pkg::MODE_CHARGE) begin
                    high_after = i_cfg.charge_high;
                end else if (mode == vsb_pkg::MODE_RUNNING) begin
                    high_after = i_cfg.running_high;
                end
                if (gt_cfg(sb, i_cfg.slow_period)) begin
                    led = 1'b0;
                    sb  = '0;
                end
                if (gt_cfg(sb, high_after)) begin
                    led = 1'b1;
                end
            end
            vsb_pkg::MODE_OPEN, vsb_pkg::MODE_CLOSE: begin
                if (gt_cfg(sb, i_cfg.fast_period)) begin
                    led = 1'b0;
                    sb  = '0;
                end else if (gt_cfg(sb, i_cfg.fast_high)) begin
                    led = 1'b1;
                end
                // timed move; the blink timer keeps running
                if (gt_cfg(sc, i_cfg.transition)) begin
                    sc = '0;
                    if (mode == vsb_pkg::MODE_OPEN) begin
                        mode = vsb_pkg::MODE_AFTER_OPEN;
                    end else begin
                        mode = vsb_pkg::MODE_IDLE;
                        led  = 1'b0;
                    end
                end
            end
            vsb_pkg::MODE_AFTER_OPEN: begin
                led = 1'b1;
            end
            default: begin
            end
        endcase

        o_mode         = mode;
        o_since_change = sc;
        o_since_blink  = sb;
        o_led          = led;
        o_drive.boost  = (mode == vsb_pkg::MODE_CHARGE) || (mode == vsb_pkg::MODE_OPEN)
                         || (mode == vsb_pkg::MODE_RUNNING);
        o_drive.buck   = (mode == vsb_pkg::MODE_OPEN) || (mode == vsb_pkg::MODE_CLOSE);
        o_drive.open   = (mode == vsb_pkg::MODE_OPEN);
    end

endmodule

[rtl/valve_sequencer_with_status_blink.sv]
// Top level of the valve sequencer with status blink: state registers,
// configuration registers and the result register. Depends on vsb_pkg,
// vsb_step and valve_sequencer_with_status_blink_assert.svh.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+----------------------------------
//  in      | input     | i_in_valid/o_in_ready  | i_button_pressed
//  out     | output    | o_out_valid/i_out_ready| o_mode, o_led_level, o_*_drive
//  cfg     | input     | i_cfg_we (no wait)     | i_cfg_idx, i_cfg_data
//
// Each tick word is handled by one pass of compare logic in vsb_step, and a new
// word is accepted every cycle while the result register is empty or being
// drained. The result register holds a word the output side has not yet taken;
// while it is full and i_out_ready is low, o_in_ready drops. Synchronous
// active-low reset puts the sequencer in idle with LED high, both timers at zero,
// the configuration registers at their defaults and the result register empty.
`timescale 1ns / 1ps
`include "valve_sequencer_with_status_blink_assert.svh"

module valve_sequencer_with_status_blink #(
    parameter int TIMER_BITS = vsb_pkg::TIMER_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // tick input
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic                                 i_button_pressed,
    // result output
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [2:0]                           o_mode,
    output logic                                 o_led_level,
    output logic                                 o_boost_drive,
    output logic                                 o_buck_drive,
    output logic                                 o_open_drive,
    // configuration writes
    input  logic                                 i_cfg_we,
    input  logic [vsb_pkg::CFG_IDX_BITS-1:0]     i_cfg_idx,
    input  logic [vsb_pkg::CFG_BITS-1:0]         i_cfg_data
);

    // sequencer state
    vsb_pkg::t_mode        r_mode,  n_mode;
    logic [TIMER_BITS-1:0] r_since_change, n_since_change;
    logic [TIMER_BITS-1:0] r_since_blink,  n_since_blink;
    logic                  r_led,   n_led;
    vsb_pkg::t_drive       n_drive;

    // configuration
    vsb_pkg::t_cfg         r_cfg;

    // result register
    logic                  r_out_valid;
    vsb_pkg::t_mode        r_out_mode;
    logic                  r_out_led;
    vsb_pkg::t_drive       r_out_drive;

    logic                  in_accept;

    // take a word whenever the result slot is free or drains this cycle
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_accept  = i_in_valid && o_in_ready;

    vsb_step #(
        .TIMER_BITS (TIMER_BITS)
    ) u_step (
        .i_mode         (r_mode),
        .i_since_change (r_since_change),
        .i_since_blink  (r_since_blink),
        .i_led          (r_led),
        .i_press        (i_button_pressed),
        .i_cfg          (r_cfg),
        .o_mode         (n_mode),
        .o_since_change (n_since_change),
        .o_since_blink  (n_since_blink),
        .o_led          (n_led),
        .o_drive        (n_drive)
    );

    // state register: advance only on an accepted tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= vsb_pkg::MODE_IDLE;
            r_since_change <= '0;
            r_since_blink  <= '0;
            r_led          <= 1'b1;
        end else if (in_accept) begin
            r_mode         <= n_mode;
            r_since_change <= n_since_change;
            r_since_blink  <= n_since_blink;
            r_led          <= n_led;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.lockout      <= vsb_pkg::RST_LOCKOUT;
            r_cfg.transition   <= vsb_pkg::RST_TRANSITION;
            r_cfg.slow_period  <= vsb_pkg::RST_SLOW_PERIOD;
            r_cfg.idle_high    <= vsb_pkg::RST_IDLE_HIGH;
            r_cfg.charge_high  <= vsb_pkg::RST_CHARGE_HIGH;
            r_cfg.running_high <= vsb_pkg::RST_RUNNING_HIGH;
            r_cfg.fast_period  <= vsb_pkg::RST_FAST_PERIOD;
            r_cfg.fast_high    <= vsb_pkg::RST_FAST_HIGH;
        end else if (i_cfg_we) begin
            case (vsb_pkg::t_cfg_idx'(i_cfg_idx))
                vsb_pkg::CFG_LOCKOUT:      r_cfg.lockout      <= i_cfg_data;
                vsb_pkg::CFG_TRANSITION:   r_cfg.transition   <= i_cfg_data;
                vsb_pkg::CFG_SLOW_PERIOD:  r_cfg.slow_period  <= i_cfg_data;
                vsb_pkg::CFG_IDLE_HIGH:    r_cfg.idle_high    <= i_cfg_data;
                vsb_pkg::CFG_CHARGE_HIGH:  r_cfg.charge_high  <= i_cfg_data;
                vsb_pkg::CFG_RUNNING_HIGH: r_cfg.running_high <= i_cfg_data;
                vsb_pkg::CFG_FAST_PERIOD:  r_cfg.fast_period  <= i_cfg_data;
                vsb_pkg::CFG_FAST_HIGH:    r_cfg.fast_high    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // result valid: set on accept, drop when taken without a new word behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload: load with the post-tick state
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out_mode  <= n_mode;
            r_out_led   <= n_led;
            r_out_drive <= n_drive;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_mode        = r_out_mode;
    assign o_led_level   = r_out_led;
    assign o_boost_drive = r_out_drive.boost;
    assign o_buck_drive  = r_out_drive.buck;
    assign o_open_drive  = r_out_drive.open;

    // open drive comes only with boost and buck both on
    `VSB_ASSERT_IMPL(a_open_decode, i_clk, i_rst_n, r_out_valid && r_out_drive.open, r_out_drive.boost && r_out_drive.buck)
    // state holds between accepted ticks
    `VSB_ASSERT_NEXT(a_state_hold, i_clk, i_rst_n, !in_accept, $stable(r_mode) && $stable(r_since_blink))
    // open leaves only for after_open
    `VSB_ASSERT_NEXT(a_open_exit, i_clk, i_rst_n, in_accept && (r_mode == vsb_pkg::MODE_OPEN), (r_mode == vsb_pkg::MODE_OPEN) || (r_mode == vsb_pkg::MODE_AFTER_OPEN))
    // after_open without a press keeps the LED lit
    `VSB_ASSERT_NEXT(a_after_open_led, i_clk, i_rst_n, in_accept && !i_button_pressed && (r_mode == vsb_pkg::MODE_AFTER_OPEN), r_led)

endmodule

[tb/valve_sequencer_with_status_blink_tb.sv]
// Self-checking bench for valve_sequencer_with_status_blink: predicts every status word
// per tick and checks it field by field. Depends on vsb_pkg and the block's RTL only.
`timescale 1ns / 1ps

module valve_sequencer_with_status_blink_tb;
    import vsb_pkg::*;

    localparam int TIMER_W = TIMER_BITS_DEF;

    // Register settings used between phases
    localparam int PLAN_SMALL   = 0;
    localparam int PLAN_ZERO    = 1;
    localparam int PLAN_MAX     = 2;
    localparam int PLAN_MIXED   = 3;
    localparam int PLAN_DEFAULT = 4;

    localparam int PHASE_COUNT = 9;
    localparam int PHASE_PLAN [PHASE_COUNT] = '{PLAN_SMALL, PLAN_ZERO, PLAN_SMALL, PLAN_MIXED,
                                                PLAN_SMALL, PLAN_MAX, PLAN_MIXED, PLAN_SMALL,
                                                PLAN_DEFAULT};
    localparam int PHASE_TICKS  = 175;
    localparam int GAP_CAP = 40;

    typedef struct packed {
        t_mode mode;
        logic  led;
        logic  boost;
        logic  buck;
        logic  valve_open;
    } status_t;

    // Tracks the sequencer state per accepted tick and holds the status words
    // still owed by the block, oldest first.
    class valve_scoreboard;
        logic [CFG_BITS-1:0] regs [8];
        t_mode               mode;
        logic [TIMER_W-1:0]  since_change;
        logic [TIMER_W-1:0]  since_blink;
        logic                led;
        status_t             pending_status [$];
        int                  errors;

        function new();
            regs[CFG_LOCKOUT]      = RST_LOCKOUT;
            regs[CFG_TRANSITION]   = RST_TRANSITION;
            regs[CFG_SLOW_PERIOD]  = RST_SLOW_PERIOD;
            regs[CFG_IDLE_HIGH]    = RST_IDLE_HIGH;
            regs[CFG_CHARGE_HIGH]  = RST_CHARGE_HIGH;
            regs[CFG_RUNNING_HIGH] = RST_RUNNING_HIGH;
            regs[CFG_FAST_PERIOD]  = RST_FAST_PERIOD;
            regs[CFG_FAST_HIGH]    = RST_FAST_HIGH;
            mode         = MODE_IDLE;
            since_change = '0;
            since_blink  = '0;
            led          = 1'b1;
            errors       = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [CFG_BITS-1:0] val);
            regs[idx] = val;
        endfunction

        function logic [TIMER_W-1:0] bump(logic [TIMER_W-1:0] v);
            return (&v) ? v : v + 1'b1;
        endfunction

        function void slow_pattern(logic [CFG_BITS-1:0] high_after);
            if (since_blink > regs[CFG_SLOW_PERIOD]) begin
                led         = 1'b0;
                since_blink = '0;
            end
            if (since_blink > high_after)
                led = 1'b1;
        endfunction

        // Fast blink for open/close; report when the transition time ran out
        function bit fast_pattern_done();
            if (since_blink > regs[CFG_FAST_PERIOD]) begin
                led         = 1'b0;
                since_blink = '0;
            end else if (since_blink > regs[CFG_FAST_HIGH]) begin
                led = 1'b1;
            end
            if (since_change > regs[CFG_TRANSITION]) begin
                since_change = '0;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void note_tick(bit pressed);
            status_t s;
            since_change = bump(since_change);
            since_blink  = bump(since_blink);
            if (pressed && since_change > regs[CFG_LOCKOUT]) begin
                mode         = (mode == MODE_CLOSE) ? MODE_IDLE : t_mode'(mode + 3'd1);
                since_change = '0;
                since_blink  = '0;
                led          = 1'b0;
            end
            case (mode)
                MODE_IDLE:       slow_pattern(regs[CFG_IDLE_HIGH]);
                MODE_CHARGE:     slow_pattern(regs[CFG_CHARGE_HIGH]);
                MODE_RUNNING:    slow_pattern(regs[CFG_RUNNING_HIGH]);
                MODE_OPEN: begin
                    if (fast_pattern_done())
                        mode = MODE_AFTER_OPEN;
                end
                MODE_CLOSE: begin
                    if (fast_pattern_done()) begin
                        mode = MODE_IDLE;
                        led  = 1'b0;
                    end
                end
                MODE_AFTER_OPEN: led = 1'b1;
                default: ;
            endcase
            s.mode       = mode;
            s.led        = led;
            s.boost      = (mode == MODE_CHARGE) || (mode == MODE_OPEN) || (mode == MODE_RUNNING);
            s.buck       = (mode == MODE_OPEN) || (mode == MODE_CLOSE);
            s.valve_open = (mode == MODE_OPEN);
            pending_status.push_back(s);
        endfunction

        function void check_status(status_t got);
            status_t want;
            if (pending_status.size() == 0) begin
                $error("status word with no prediction waiting: mode %0d led %0b",
                       got.mode, got.led);
                errors++;
                return;
            end
            want = pending_status.pop_front();
            if (got.mode !== want.mode) begin
                $error("mode: expected %0d, got %0d", want.mode, got.mode);
                errors++;
            end
            if (got.led !== want.led) begin
                $error("led_level: expected %0b, got %0b", want.led, got.led);
                errors++;
            end
            if (got.boost !== want.boost) begin
                $error("boost_drive: expected %0b, got %0b", want.boost, got.boost);
                errors++;
            end
            if (got.buck !== want.buck) begin
                $error("buck_drive: expected %0b, got %0b", want.buck, got.buck);
                errors++;
            end
            if (got.valve_open !== want.valve_open) begin
                $error("open_drive: expected %0b, got %0b", want.valve_open, got.valve_open);
                errors++;
            end
        endfunction
    endclass

    // Every input starts at a known level
    logic                    i_clk            = 1'b0;
    logic                    i_rst_n          = 1'b0;
    logic                    i_in_valid       = 1'b0;
    logic                    o_in_ready;
    logic                    i_button_pressed = 1'b0;
    logic                    o_out_valid;
    logic                    i_out_ready      = 1'b0;
    logic [2:0]              o_mode;
    logic                    o_led_level;
    logic                    o_boost_drive;
    logic                    o_buck_drive;
    logic                    o_open_drive;
    logic                    i_cfg_we         = 1'b0;
    logic [CFG_IDX_BITS-1:0] i_cfg_idx        = '0;
    logic [CFG_BITS-1:0]     i_cfg_data       = '0;

    valve_sequencer_with_status_blink u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_button_pressed (i_button_pressed),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_mode           (o_mode),
        .o_led_level      (o_led_level),
        .o_boost_drive    (o_boost_drive),
        .o_buck_drive     (o_buck_drive),
        .o_open_drive     (o_open_drive),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data)
    );

    valve_scoreboard     board;
    logic [CFG_BITS-1:0] plan [8];
    int                  stall_pct = 0;

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Output side: check each word taken, then pick ready for the next edge.
    // Outputs are read right after the edge, so they still hold the word
    // that the edge moved.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready)
            board.check_status(status_t'{mode: t_mode'(o_mode), led: o_led_level,
                                         boost: o_boost_drive, buck: o_buck_drive,
                                         valve_open: o_open_drive});
        i_out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Offer one tick word after a random idle gap; hold valid and payload
    // until the block takes it, then record it with the scoreboard.
    task automatic push_tick(input bit pressed, input int idle_pct);
        int gap;
        gap = 0;
        while (gap < GAP_CAP && $urandom_range(99) < idle_pct)
            gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_button_pressed <= pressed;
        do
            @(posedge i_clk);
        while (o_in_ready !== 1'b1);
        board.note_tick(pressed);
    endtask

    // Drop valid and wait out every owed word plus the result stage
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (board.pending_status.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Write all eight registers from plan, one per cycle, while the block is idle
    task automatic write_settings();
        t_cfg_idx r;
        r = r.first();
        do begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= r;
            i_cfg_data <= plan[r];
            @(posedge i_clk);
            board.set_reg(r, plan[r]);
            r = r.next();
        end while (r != r.first());
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [CFG_BITS-1:0] wild_value();
        case ($urandom_range(3))
            0:       return '0;
            1:       return '1;
            2:       return CFG_BITS'($urandom_range(2047));
            default: return CFG_BITS'($urandom_range(40));
        endcase
    endfunction

    task automatic fill_plan(input int kind);
        case (kind)
            PLAN_ZERO: begin
                foreach (plan[k]) plan[k] = '0;
            end
            PLAN_MAX: begin
                // nothing can be exceeded within a phase: the state stays where it was
                foreach (plan[k]) plan[k] = '1;
            end
            PLAN_MIXED: begin
                foreach (plan[k]) plan[k] = wild_value();
                plan[CFG_LOCKOUT] = $urandom_range(1) ? '0 : CFG_BITS'($urandom_range(60));
            end
            PLAN_DEFAULT: begin
                plan[CFG_LOCKOUT]      = RST_LOCKOUT;
                plan[CFG_TRANSITION]   = RST_TRANSITION;
                plan[CFG_SLOW_PERIOD]  = RST_SLOW_PERIOD;
                plan[CFG_IDLE_HIGH]    = RST_IDLE_HIGH;
                plan[CFG_CHARGE_HIGH]  = RST_CHARGE_HIGH;
                plan[CFG_RUNNING_HIGH] = RST_RUNNING_HIGH;
                plan[CFG_FAST_PERIOD]  = RST_FAST_PERIOD;
                plan[CFG_FAST_HIGH]    = RST_FAST_HIGH;
            end
            default: begin
                // short times so presses walk through all six states often;
                // high-after values may exceed their period on purpose
                plan[CFG_LOCKOUT]      = CFG_BITS'($urandom_range(20));
                plan[CFG_TRANSITION]   = CFG_BITS'($urandom_range(30));
                plan[CFG_SLOW_PERIOD]  = CFG_BITS'($urandom_range(40));
                plan[CFG_IDLE_HIGH]    = CFG_BITS'($urandom_range(45));
                plan[CFG_CHARGE_HIGH]  = CFG_BITS'($urandom_range(45));
                plan[CFG_RUNNING_HIGH] = CFG_BITS'($urandom_range(45));
                plan[CFG_FAST_PERIOD]  = CFG_BITS'($urandom_range(12));
                plan[CFG_FAST_HIGH]    = CFG_BITS'($urandom_range(14));
            end
        endcase
    endtask

    initial begin
        // press, press, three quiet ticks (open times out), press, press,
        // four quiet ticks (close times out), six presses round the ring,
        // then quiet ticks for the idle blink
        logic [20:0] walk;
        int          send_pct;
        int          press_pct;

        walk  = 21'b1_1000_1100_0011_1111_0000;
        board = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Presses inside the reset lockout must not advance
        push_tick(1'b0, 0);
        push_tick(1'b1, 0);
        push_tick(1'b1, 0);
        push_tick(1'b0, 0);
        wait_drained();

        plan[CFG_LOCKOUT]      = '0;
        plan[CFG_TRANSITION]   = CFG_BITS'(2);
        plan[CFG_SLOW_PERIOD]  = CFG_BITS'(3);
        plan[CFG_IDLE_HIGH]    = '0;
        plan[CFG_CHARGE_HIGH]  = CFG_BITS'(1);
        plan[CFG_RUNNING_HIGH] = CFG_BITS'(2);
        plan[CFG_FAST_PERIOD]  = CFG_BITS'(1);
        plan[CFG_FAST_HIGH]    = '0;
        write_settings();
        for (int i = 20; i >= 0; i--)
            push_tick(walk[i], 0);
        wait_drained();

        // Random phases: new settings, a new idle mix and a new press density each
        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            fill_plan(PHASE_PLAN[ph]);
            write_settings();
            case (ph % 4)
                0: begin send_pct = 0;  stall_pct = 0;  end
                1: begin send_pct = 64; stall_pct = 0;  end
                2: begin send_pct = 0;  stall_pct = 64; end
                default: begin send_pct = 31; stall_pct = 31; end
            endcase
            press_pct = $urandom_range(90, 10);
            repeat (PHASE_TICKS)
                push_tick($urandom_range(99) < press_pct, send_pct);
            wait_drained();
        end

        if (board.errors == 0 && board.pending_status.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Hard stop well past the slowest legal run
    initial begin
        #20_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
